@@ src/rsd_pkg.sv @@
// ----------------------------------------------------------------------------
// rsd_pkg
// Shared types and constants of the RTP STAP-A depacketizer.
// ----------------------------------------------------------------------------
package rsd_pkg;

  // Input transaction: one RTP packet byte
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } rsd_in_t;

  // Output transaction: one Annex-B stream byte
  typedef struct packed {
    logic [7:0] out_byte;
    logic       nal_end;
    logic       cut_short;
    logic       run_last;
  } rsd_out_t;

  // Results caused by one input byte: optional start code, optional data byte
  typedef struct packed {
    logic       has_start;
    logic       st_end;
    logic       st_cut;
    logic       has_data;
    logic [7:0] data_byte;
    logic       d_end;
    logic       d_cut;
  } rsd_desc_t;

  // Seen map: 65536 bits stored as 8192 bytes
  localparam int SEEN_WORDS = 8192;
  localparam int SEEN_AW    = $clog2(SEEN_WORDS);
  localparam int SEEN_DW    = 8;
  localparam int CLR_CNT_W  = SEEN_AW;

  // Protocol constants
  localparam logic [4:0] STAP_A_TYPE = 5'd24;
  localparam logic [4:0] SPS_TYPE    = 5'd7;
  localparam int         EXT_BIT     = 4;
  localparam logic [3:0] FIXED_LEN   = 4'd12;
  localparam logic [7:0] START_ZERO  = 8'h00;
  localparam logic [7:0] START_ONE   = 8'h01;

endpackage

@@ src/rsd_ram.sv @@
// ----------------------------------------------------------------------------
// rsd_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ src/rsd_parser.sv @@
// ----------------------------------------------------------------------------
// rsd_parser
// RTP header / STAP-A parser with the sequence-number seen map in RAM.
// ----------------------------------------------------------------------------
module rsd_parser import rsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_fire,
  input  rsd_in_t   in_data,
  output logic      busy,
  output logic      desc_push,
  output rsd_desc_t desc
);

  typedef enum logic [7:0] {
    PH_FIXED   = 8'b0000_0001,
    PH_EXTHDR  = 8'b0000_0010,
    PH_SKIP    = 8'b0000_0100,
    PH_PLHDR   = 8'b0000_1000,
    PH_SIZE_HI = 8'b0001_0000,
    PH_SIZE_LO = 8'b0010_0000,
    PH_DATA    = 8'b0100_0000,
    PH_DROP    = 8'b1000_0000
  } phase_t;

  phase_t               phase_r, phase_nxt, phase_eff;
  logic [3:0]           idx_r, idx_nxt, idx_inc;
  logic                 ext_r, ext_nxt;
  logic [7:0]           seq_hi_r, seq_hi_nxt;
  logic [17:0]          skip_r, skip_nxt;
  logic [7:0]           size_hi_r, size_hi_nxt;
  logic [15:0]          unit_r, unit_nxt;
  logic                 sps_r, sps_nxt;
  logic                 chk_pend_r, chk_pend_nxt;
  logic                 chk_live_r, chk_live_nxt;
  logic [2:0]           chk_bit_r, chk_bit_nxt;
  logic [SEEN_AW-1:0]   chk_addr_r, chk_addr_nxt;
  logic                 clearing_r;
  logic [CLR_CNT_W-1:0] clr_cnt_r;

  logic [SEEN_AW-1:0]   ram_raddr, ram_waddr;
  logic [SEEN_DW-1:0]   ram_rdata, ram_wdata;
  logic                 ram_we;
  logic                 hit, drop_now;
  logic [7:0]           b;
  logic                 last;
  logic [15:0]          size_full;
  logic [15:0]          unit_dec;
  logic                 first, done, cut;
  rsd_desc_t            desc_nxt;

  assign b    = in_data.in_byte;
  assign last = in_data.in_last;
  assign busy = clearing_r;

  // Seen-map lookup result, valid in the cycle after the read
  assign hit      = ram_rdata[chk_bit_r];
  assign drop_now = chk_pend_r && chk_live_r && hit;
  assign phase_eff = drop_now ? PH_DROP : phase_r;

  // RAM write port: clearing pass, else mark sequence number seen
  always_comb begin
    if (clearing_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r[SEEN_AW-1:0];
      ram_wdata = '0;
    end else begin
      ram_we    = chk_pend_r && !hit;
      ram_waddr = chk_addr_r;
      ram_wdata = ram_rdata | (SEEN_DW'(1) << chk_bit_r);
    end
  end

  assign ram_raddr = {seq_hi_r, b[7:3]};

  rsd_ram #(
    .WIDTH (SEEN_DW),
    .DEPTH (SEEN_WORDS)
  ) u_seen_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign idx_inc   = idx_r + 4'd1;
  assign size_full = {size_hi_r, b};
  assign unit_dec  = (unit_r != 16'd0) ? unit_r - 16'd1 : unit_r;

  // Parse state machine, one input byte per transaction
  always_comb begin
    phase_nxt    = drop_now ? PH_DROP : phase_r;
    idx_nxt      = idx_r;
    ext_nxt      = ext_r;
    seq_hi_nxt   = seq_hi_r;
    skip_nxt     = skip_r;
    size_hi_nxt  = size_hi_r;
    unit_nxt     = unit_r;
    sps_nxt      = sps_r;
    chk_pend_nxt = 1'b0;
    chk_live_nxt = chk_live_r;
    chk_bit_nxt  = chk_bit_r;
    chk_addr_nxt = chk_addr_r;
    desc_nxt     = '0;
    first        = 1'b0;
    done         = 1'b0;
    cut          = 1'b0;

    if (in_fire) begin
      case (phase_eff)
        PH_FIXED: begin
          if (idx_r == 4'd0) ext_nxt = b[EXT_BIT];
          if (idx_r == 4'd2) seq_hi_nxt = b;
          if (idx_r == 4'd3) begin
            chk_pend_nxt = 1'b1;
            chk_live_nxt = !last;
            chk_bit_nxt  = b[2:0];
            chk_addr_nxt = ram_raddr;
          end
          idx_nxt = idx_inc;
          if (idx_inc >= FIXED_LEN) begin
            idx_nxt   = 4'd0;
            phase_nxt = ext_r ? PH_EXTHDR : PH_PLHDR;
          end
        end
        PH_EXTHDR: begin
          if (idx_r == 4'd2) size_hi_nxt = b;
          if (idx_r >= 4'd3) begin
            skip_nxt  = {size_full, 2'b00};
            idx_nxt   = 4'd0;
            phase_nxt = (size_full != 16'd0) ? PH_SKIP : PH_PLHDR;
          end else begin
            idx_nxt = idx_inc;
          end
        end
        PH_SKIP: begin
          if (skip_r != 18'd0) skip_nxt = skip_r - 18'd1;
          if (skip_nxt == 18'd0) phase_nxt = PH_PLHDR;
        end
        PH_PLHDR: begin
          phase_nxt = (b[4:0] == STAP_A_TYPE) ? PH_SIZE_HI : PH_DROP;
        end
        PH_SIZE_HI: begin
          size_hi_nxt = b;
          phase_nxt   = PH_SIZE_LO;
        end
        PH_SIZE_LO: begin
          unit_nxt = size_full;
          if (size_full == 16'd0) begin
            desc_nxt.has_start = sps_r;
            desc_nxt.st_end    = 1'b1;
            phase_nxt          = PH_SIZE_HI;
          end else if (last) begin
            desc_nxt.has_start = sps_r;
            desc_nxt.st_end    = 1'b1;
            desc_nxt.st_cut    = 1'b1;
          end else begin
            idx_nxt   = 4'd1;
            phase_nxt = PH_DATA;
          end
        end
        PH_DATA: begin
          first = (idx_r == 4'd1);
          if (first && b[4:0] == SPS_TYPE) sps_nxt = 1'b1;
          if (first) idx_nxt = 4'd0;
          unit_nxt = unit_dec;
          done     = (unit_dec == 16'd0);
          cut      = !done && last;
          desc_nxt.has_start = first && sps_nxt;
          desc_nxt.has_data  = sps_nxt;
          desc_nxt.data_byte = b;
          desc_nxt.d_end     = done || cut;
          desc_nxt.d_cut     = cut;
          if (done) phase_nxt = PH_SIZE_HI;
        end
        default: begin
        end
      endcase

      // Packet end returns to the fixed header
      if (last) begin
        phase_nxt = PH_FIXED;
        idx_nxt   = 4'd0;
        ext_nxt   = 1'b0;
        skip_nxt  = 18'd0;
        unit_nxt  = 16'd0;
      end
    end
  end

  assign desc_push = in_fire && (desc_nxt.has_start || desc_nxt.has_data);
  assign desc      = desc_nxt;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_FIXED;
      idx_r      <= 4'd0;
      ext_r      <= 1'b0;
      seq_hi_r   <= 8'd0;
      skip_r     <= 18'd0;
      size_hi_r  <= 8'd0;
      unit_r     <= 16'd0;
      sps_r      <= 1'b0;
      chk_pend_r <= 1'b0;
      chk_live_r <= 1'b0;
      clearing_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else begin
      phase_r    <= phase_nxt;
      idx_r      <= idx_nxt;
      ext_r      <= ext_nxt;
      seq_hi_r   <= seq_hi_nxt;
      skip_r     <= skip_nxt;
      size_hi_r  <= size_hi_nxt;
      unit_r     <= unit_nxt;
      sps_r      <= sps_nxt;
      chk_pend_r <= chk_pend_nxt;
      chk_live_r <= chk_live_nxt;
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + CLR_CNT_W'(1);
        if (clr_cnt_r == CLR_CNT_W'(SEEN_WORDS - 1)) clearing_r <= 1'b0;
      end
    end
  end

  // Pending lookup payload
  always_ff @(posedge clk) begin
    chk_bit_r  <= chk_bit_nxt;
    chk_addr_r <= chk_addr_nxt;
  end

endmodule

@@ src/rsd_out_queue.sv @@
// ----------------------------------------------------------------------------
// rsd_out_queue
// Two-entry result queue; expands each entry into start code and data bytes.
// ----------------------------------------------------------------------------
module rsd_out_queue import rsd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  rsd_desc_t push_desc,
  output logic      can_push,
  output logic      out_valid,
  input  logic      out_ready,
  output rsd_out_t  out_data
);

  rsd_desc_t  s0_r, s0_nxt, s1_r, s1_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic [2:0] pos_r, pos_nxt;
  logic       res_last, in_start, pop;

  assign can_push  = (cnt_r != 2'd2);
  assign out_valid = (cnt_r != 2'd0);

  // Current result of the head entry
  assign in_start = s0_r.has_start && !pos_r[2];
  always_comb begin
    if (s0_r.has_start) begin
      res_last = s0_r.has_data ? (pos_r == 3'd4) : (pos_r == 3'd3);
    end else begin
      res_last = 1'b1;
    end
    if (in_start) begin
      out_data.out_byte  = (pos_r == 3'd3) ? START_ONE : START_ZERO;
      out_data.nal_end   = (pos_r == 3'd3) && s0_r.st_end;
      out_data.cut_short = (pos_r == 3'd3) && s0_r.st_cut;
    end else begin
      out_data.out_byte  = s0_r.data_byte;
      out_data.nal_end   = s0_r.d_end;
      out_data.cut_short = s0_r.d_cut;
    end
    out_data.run_last = res_last;
  end

  assign pop = out_valid && out_ready && res_last;

  // Queue update
  always_comb begin
    s0_nxt  = s0_r;
    s1_nxt  = s1_r;
    cnt_nxt = cnt_r;
    pos_nxt = pos_r;
    if (out_valid && out_ready) begin
      pos_nxt = res_last ? 3'd0 : pos_r + 3'd1;
    end
    if (pop) begin
      s0_nxt = s1_r;
    end
    if (push) begin
      if ((pop && cnt_r == 2'd1) || cnt_r == 2'd0) begin
        s0_nxt = push_desc;
      end else begin
        s1_nxt = push_desc;
      end
    end
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (pop && !push) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      pos_r <= 3'd0;
    end else begin
      cnt_r <= cnt_nxt;
      pos_r <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s0_r <= s0_nxt;
    s1_r <= s1_nxt;
  end

endmodule

@@ src/rtp_stap_a_depacketizer_top.sv @@
// ----------------------------------------------------------------------------
// rtp_stap_a_depacketizer_top
// RTP H.264 STAP-A depacketizer producing an Annex-B byte stream.
// ----------------------------------------------------------------------------
//  channel | ports                          | payload
//  --------+--------------------------------+------------------------------
//  input   | in_valid, in_ready, in_data    | in_byte, in_last
//  output  | out_valid, out_ready, out_data | out_byte, nal_end, cut_short,
//          |                                |   run_last
//
//  One input transaction per cycle while in_ready is high; each yields 0, 1,
//  4 or 5 output bytes, one per cycle while out_ready is high, from a two-entry
//  result queue. After reset the seen-map RAM is cleared, all 8192 words, with
//  in_ready low. The duplicate check reads the seen-map RAM on header byte 3
//  and resolves in the next cycle, writing the marked word back. After the
//  clearing pass, in_ready falls only when the result queue holds two entries.
// ----------------------------------------------------------------------------
module rtp_stap_a_depacketizer_top import rsd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  rsd_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output rsd_out_t out_data
);

  logic      busy, can_push, in_fire, desc_push;
  rsd_desc_t desc;

  assign in_ready = !busy && can_push;
  assign in_fire  = in_valid && in_ready;

  rsd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_data   (in_data),
    .busy      (busy),
    .desc_push (desc_push),
    .desc      (desc)
  );

  rsd_out_queue u_out_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (desc_push),
    .push_desc (desc),
    .can_push  (can_push),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ verif/tb_rtp_stap_a_depacketizer_top.sv @@
// ----------------------------------------------------------------------------
// tb_rtp_stap_a_depacketizer_top
// Self-checking bench for the RTP STAP-A depacketizer. RTP packets are
// built as byte streams: first hand-picked ones for the corner cases, then
// random ones, mostly well-formed. A local model of the parser predicts the
// Annex-B output, and the monitor compares every output transaction field by
// field. Sender gaps and receiver stalls vary by phase, and there is one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module tb_rtp_stap_a_depacketizer_top import rsd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int         WATCHDOG_LIMIT = 40000;
  localparam int         DRAIN_CYCLES   = 32;
  localparam int         HOLD_CYCLES    = 400;
  localparam int         RANDOM_BYTES   = 24;
  localparam int         MAX_PRINTS     = 100;
  localparam logic [4:0] FU_A_TYPE      = 5'd28;
  localparam logic [4:0] IDR_TYPE       = 5'd5;
  localparam logic [4:0] PPS_TYPE       = 5'd8;

  // Parser phases of the local model
  typedef enum logic [7:0] {
    PH_FIXED   = 8'b0000_0001,
    PH_EXTHDR  = 8'b0000_0010,
    PH_SKIP    = 8'b0000_0100,
    PH_PLHDR   = 8'b0000_1000,
    PH_SIZE_HI = 8'b0001_0000,
    PH_SIZE_LO = 8'b0010_0000,
    PH_DATA    = 8'b0100_0000,
    PH_DROP    = 8'b1000_0000
  } parse_phase_t;

  logic     clk       = 1'b0;
  logic     rst_n     = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  rsd_in_t  in_data   = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  rsd_out_t out_data;

  rtp_stap_a_depacketizer_top DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // Clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus and expectation stores
  rsd_in_t     rtp_byte_q[$];
  logic [7:0]  pkt_q[$];
  rsd_out_t    annexb_expect_q[$];
  rsd_out_t    step_res_q[$];
  int          total_items = 1;
  int          in_acc_cnt  = 0;
  int          out_cnt     = 0;
  int          err_cnt     = 0;

  // Model state
  bit           seq_seen [65536];
  logic         sps_found  = 1'b0;
  parse_phase_t phase      = PH_FIXED;
  logic [3:0]   hdr_idx    = '0;
  logic         ext_flag   = 1'b0;
  logic [7:0]   seq_hi     = '0;
  logic [17:0]  skip_left  = '0;
  logic [7:0]   size_hi    = '0;
  logic [15:0]  unit_left  = '0;

  // Idle phases: none, sender gaps, receiver stalls, both
  int idle_phase;
  int send_idle_pct;
  int recv_stall_pct;
  always_comb begin
    idle_phase     = (in_acc_cnt * 4) / total_items;
    send_idle_pct  = (idle_phase == 1) ? 63 : (idle_phase >= 3) ? 30 : 0;
    recv_stall_pct = (idle_phase == 2) ? 63 : (idle_phase >= 3) ? 30 : 0;
  end

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("MISMATCH at result %0d: %s", out_cnt, msg);
    err_cnt++;
  endtask

  // ---------------- packet building ----------------
  task automatic add_fixed_header(input logic ext, input logic [15:0] seq);
    logic [7:0] b0;
    b0          = 8'($urandom);
    b0[EXT_BIT] = ext;
    pkt_q.push_back(b0);
    pkt_q.push_back(8'($urandom));
    pkt_q.push_back(seq[15:8]);
    pkt_q.push_back(seq[7:0]);
    repeat (8) pkt_q.push_back(8'($urandom));
  endtask

  task automatic add_ext(input logic [15:0] words);
    pkt_q.push_back(8'($urandom));
    pkt_q.push_back(8'($urandom));
    pkt_q.push_back(words[15:8]);
    pkt_q.push_back(words[7:0]);
    repeat (int'(words) * 4) pkt_q.push_back(8'($urandom));
  endtask

  // Size field, then ndata bytes starting with the NAL header byte
  task automatic add_unit(input logic [15:0] size, input logic [7:0] nal_hdr, input int ndata);
    pkt_q.push_back(size[15:8]);
    pkt_q.push_back(size[7:0]);
    for (int i = 0; i < ndata; i++) pkt_q.push_back((i == 0) ? nal_hdr : 8'($urandom));
  endtask

  // Queue the packet, truncated to keep bytes when keep is nonzero
  task automatic send_packet(input int keep);
    int n;
    n = (keep > 0 && keep < pkt_q.size()) ? keep : pkt_q.size();
    for (int i = 0; i < n; i++) begin
      rtp_byte_q.push_back('{in_byte: pkt_q[i], in_last: (i == n - 1)});
    end
    pkt_q.delete();
  endtask

  // ---------------- prediction ----------------
  task automatic push_result(input logic [7:0] b, input logic nal_end, input logic cut);
    step_res_q.push_back('{out_byte: b, nal_end: nal_end, cut_short: cut, run_last: 1'b0});
  endtask

  task automatic push_start_code(input logic nal_end, input logic cut);
    repeat (3) push_result(START_ZERO, 1'b0, 1'b0);
    push_result(START_ONE, nal_end, cut);
  endtask

  task automatic depacketize_byte(input rsd_in_t item);
    logic [7:0]  b;
    logic        lst;
    logic        done;
    logic        cut;
    logic [15:0] seq;
    b   = item.in_byte;
    lst = item.in_last;
    case (phase)
      PH_FIXED: begin
        if (hdr_idx == 4'd0) ext_flag = b[EXT_BIT];
        if (hdr_idx == 4'd2) seq_hi = b;
        seq = {seq_hi, b};
        if (hdr_idx == 4'd3 && seq_seen[seq]) begin
          phase = PH_DROP;
        end else begin
          if (hdr_idx == 4'd3) seq_seen[seq] = 1'b1;
          hdr_idx = hdr_idx + 4'd1;
          if (hdr_idx >= FIXED_LEN) begin
            hdr_idx = '0;
            phase   = ext_flag ? PH_EXTHDR : PH_PLHDR;
          end
        end
      end
      PH_EXTHDR: begin
        if (hdr_idx == 4'd2) size_hi = b;
        if (hdr_idx >= 4'd3) begin
          skip_left = {size_hi, b, 2'b00};
          hdr_idx   = '0;
          phase     = (skip_left != 0) ? PH_SKIP : PH_PLHDR;
        end else begin
          hdr_idx = hdr_idx + 4'd1;
        end
      end
      PH_SKIP: begin
        if (skip_left > 0) skip_left = skip_left - 18'd1;
        if (skip_left == 0) phase = PH_PLHDR;
      end
      PH_PLHDR: phase = (b[4:0] == STAP_A_TYPE) ? PH_SIZE_HI : PH_DROP;
      PH_SIZE_HI: begin
        size_hi = b;
        phase   = PH_SIZE_LO;
      end
      PH_SIZE_LO: begin
        unit_left = {size_hi, b};
        if (unit_left == 0) begin
          // empty unit: start code alone
          if (sps_found) push_start_code(1'b1, 1'b0);
          phase = PH_SIZE_HI;
        end else if (lst) begin
          if (sps_found) push_start_code(1'b1, 1'b1);
        end else begin
          hdr_idx = 4'd1;
          phase   = PH_DATA;
        end
      end
      PH_DATA: begin
        // first unit byte: SPS check and start code
        if (hdr_idx == 4'd1) begin
          if (b[4:0] == SPS_TYPE) sps_found = 1'b1;
          if (sps_found) push_start_code(1'b0, 1'b0);
          hdr_idx = '0;
        end
        if (unit_left > 0) unit_left = unit_left - 16'd1;
        done = (unit_left == 0);
        cut  = !done && lst;
        if (sps_found) push_result(b, done | cut, cut);
        if (done) phase = PH_SIZE_HI;
      end
      default: ;
    endcase
    if (lst) begin
      phase     = PH_FIXED;
      hdr_idx   = '0;
      ext_flag  = 1'b0;
      skip_left = '0;
      unit_left = '0;
    end
    if (step_res_q.size() > 0) step_res_q[step_res_q.size() - 1].run_last = 1'b1;
    foreach (step_res_q[i]) annexb_expect_q.push_back(step_res_q[i]);
    step_res_q.delete();
  endtask

  // ---------------- driver ----------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (rtp_byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data  <= rtp_byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------- receiver, with one long hold-off ----------------
  int hold_left = 0;
  bit hold_done = 1'b0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (!hold_done && in_acc_cnt >= total_items / 8) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // ---------------- monitor: predict, then check ----------------
  rsd_out_t want_res;
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        depacketize_byte(in_data);
        in_acc_cnt <= in_acc_cnt + 1;
      end
      if (out_valid && out_ready) begin
        if (annexb_expect_q.size() == 0) begin
          report_mismatch($sformatf("unexpected transaction, byte %02h", out_data.out_byte));
        end else begin
          want_res = annexb_expect_q.pop_front();
          if (out_data.out_byte !== want_res.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      out_data.out_byte, want_res.out_byte));
          if (out_data.nal_end !== want_res.nal_end)
            report_mismatch($sformatf("nal_end %b, expected %b",
                                      out_data.nal_end, want_res.nal_end));
          if (out_data.cut_short !== want_res.cut_short)
            report_mismatch($sformatf("cut_short %b, expected %b",
                                      out_data.cut_short, want_res.cut_short));
          if (out_data.run_last !== want_res.run_last)
            report_mismatch($sformatf("run_last %b, expected %b",
                                      out_data.run_last, want_res.run_last));
        end
        out_cnt++;
      end
    end
  end

  // ---------------- watchdog ----------------
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------- stimulus and end of test ----------------
  initial begin
    logic [15:0] used_seq_q[$];
    logic [15:0] seq;
    logic        ext;
    logic [7:0]  pl_hdr;
    logic [15:0] size;
    logic [4:0]  hdr_type;
    int          start_bytes;
    int          keep;

    // no SPS yet: nothing comes out
    add_fixed_header(1'b0, 16'h0000);
    pkt_q.push_back({3'b011, STAP_A_TYPE});
    add_unit(16'd2, {3'b011, IDR_TYPE}, 2);
    send_packet(0);

    // SPS opens the stream; CSRC count set, empty unit, trailing unit
    add_fixed_header(1'b0, 16'hFFFF);
    pkt_q[0] = 8'hAF;
    pkt_q.push_back({3'b111, STAP_A_TYPE});
    add_unit(16'd3, {3'b011, SPS_TYPE}, 3);
    add_unit(16'd0, 8'h00, 0);
    add_unit(16'd2, {3'b011, PPS_TYPE}, 2);
    pkt_q[pkt_q.size() - 1] = 8'hFF;
    send_packet(0);

    // packet ends before the low sequence byte: not marked
    add_fixed_header(1'b0, 16'h1234);
    send_packet(3);
    // packet ends on the low sequence byte: marked, so the resend is dropped
    add_fixed_header(1'b0, 16'h2345);
    send_packet(4);
    add_fixed_header(1'b0, 16'h2345);
    pkt_q.push_back({3'b011, STAP_A_TYPE});
    add_unit(16'd1, 8'h00, 1);
    send_packet(0);
    add_fixed_header(1'b0, 16'h1234);
    pkt_q.push_back({3'b011, STAP_A_TYPE});
    add_unit(16'd2, {3'b000, IDR_TYPE}, 2);
    send_packet(0);

    // extension with a word count above 255, cut inside the skipped words;
    // the skipped bytes look like a STAP-A payload that must not come out
    add_fixed_header(1'b1, 16'h0100);
    add_ext(16'h0100);
    pkt_q[16] = {3'b011, STAP_A_TYPE};
    pkt_q[17] = 8'h00;
    pkt_q[18] = 8'h01;
    pkt_q[19] = {3'b011, IDR_TYPE};
    send_packet(20);

    // extension with zero words
    add_fixed_header(1'b1, 16'h0200);
    add_ext(16'h0000);
    pkt_q.push_back({3'b011, STAP_A_TYPE});
    add_unit(16'd1, {3'b011, IDR_TYPE}, 1);
    send_packet(0);

    // packet ends inside the extension header
    add_fixed_header(1'b1, 16'h0201);
    add_ext(16'h0001);
    send_packet(14);

    // packet ends on the payload header
    add_fixed_header(1'b0, 16'h0300);
    pkt_q.push_back({3'b011, STAP_A_TYPE});
    send_packet(0);

    // packet ends after one size byte
    add_fixed_header(1'b0, 16'h0301);
    pkt_q.push_back({3'b011, STAP_A_TYPE});
    add_unit(16'd5, {3'b011, IDR_TYPE}, 5);
    send_packet(14);

    // packet ends right after a nonzero size field
    add_fixed_header(1'b0, 16'h0302);
    pkt_q.push_back({3'b011, STAP_A_TYPE});
    add_unit(16'd5, {3'b011, IDR_TYPE}, 5);
    send_packet(15);

    // largest size, cut inside the unit data
    add_fixed_header(1'b0, 16'h0303);
    pkt_q.push_back({3'b011, STAP_A_TYPE});
    add_unit(16'hFFFF, {3'b011, IDR_TYPE}, 3);
    send_packet(0);

    // other payload type: nothing
    add_fixed_header(1'b0, 16'h0304);
    pkt_q.push_back({3'b011, FU_A_TYPE});
    send_packet(0);

    used_seq_q = '{16'h0000, 16'hFFFF, 16'h1234, 16'h2345, 16'h0100, 16'h0200};

    // random packets: mostly well-formed, some cut, some noise
    start_bytes = rtp_byte_q.size();
    while (rtp_byte_q.size() - start_bytes < RANDOM_BYTES) begin
      if ($urandom_range(99) < 5) begin
        repeat ($urandom_range(1, 20)) pkt_q.push_back(8'($urandom));
        send_packet(0);
      end else begin
        if ($urandom_range(99) < 25) begin
          seq = used_seq_q[$urandom_range(used_seq_q.size() - 1)];
        end else begin
          seq = 16'($urandom);
          used_seq_q.push_back(seq);
        end
        ext = ($urandom_range(99) < 30);
        add_fixed_header(ext, seq);
        if (ext) add_ext(16'($urandom_range(3)));
        pl_hdr = ($urandom_range(99) < 85) ? {3'($urandom), STAP_A_TYPE} : 8'($urandom);
        pkt_q.push_back(pl_hdr);
        repeat ($urandom_range(1, 3)) begin
          size     = ($urandom_range(99) < 10) ? 16'd0 : 16'($urandom_range(1, 6));
          hdr_type = ($urandom_range(99) < 20) ? SPS_TYPE : 5'($urandom);
          add_unit(size, {3'($urandom), hdr_type}, int'(size));
        end
        keep = ($urandom_range(99) < 20) ? $urandom_range(1, pkt_q.size()) : 0;
        send_packet(keep);
      end
    end
    total_items = rtp_byte_q.size();

    // reset, then run until everything has drained
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    do @(negedge clk);
    while (rtp_byte_q.size() != 0 || in_valid || annexb_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
src/rsd_pkg.sv
src/rsd_ram.sv
src/rsd_parser.sv
src/rsd_out_queue.sv
src/rtp_stap_a_depacketizer_top.sv
verif/tb_rtp_stap_a_depacketizer_top.sv
